// ===== src/ber_value_encoder_macros.svh =====
// ---------------------------------------------------------------------------
// ber value encoder assertion macros
// concurrent assertion shorthands, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef BER_VALUE_ENCODER_MACROS_SVH
`define BER_VALUE_ENCODER_MACROS_SVH

// same-cycle implication
`define BVE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ber value encoder assertion failed");

// next-cycle implication
`define BVE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ber value encoder assertion failed");

`endif

// ===== src/bve_pkg.sv =====
// ---------------------------------------------------------------------------
// bve_pkg
// shared types and constants of the ber value encoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bve_pkg;

	localparam int MAX_RUN     = 5;
	localparam int RUN_W       = 3;
	localparam int VALUE_BYTES = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_SINT = 3'd0,
		OP_UINT = 3'd1,
		OP_OID  = 3'd2,
		OP_RAW  = 3'd3,
		OP_LEN  = 3'd4,
		OP_NULL = 3'd5
	} bve_op_t;

	typedef enum logic [1:0] {
		ARC_FIRST  = 2'd0,
		ARC_SECOND = 2'd1,
		ARC_LATER  = 2'd2
	} bve_arc_t;

	// encoded bytes of one item, bytes[0] goes out first
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] bytes;
		logic [RUN_W-1:0]        count;
	} bve_run_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} bve_qstat_t;

endpackage

`default_nettype wire

// ===== src/bve_in_if.sv =====
// ---------------------------------------------------------------------------
// bve_in_if
// value element channel: valid, ready and element payload
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bve_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] value_word;
	logic        last_element;

	modport source (output valid, operation, value_word, last_element, input ready);
	modport sink (input valid, operation, value_word, last_element, output ready);
endinterface

`default_nettype wire

// ===== src/bve_out_if.sv =====
// ---------------------------------------------------------------------------
// bve_out_if
// encoded byte channel: valid, ready and byte payload
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bve_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	logic [2:0] run_length;

	modport source (output valid, out_byte, last_byte, run_length, input ready);
	modport sink (input valid, out_byte, last_byte, run_length, output ready);
endinterface

`default_nettype wire

// ===== src/ber_value_encoder.sv =====
// an item's first byte is offered once its run is written into the run queue and is at its head
// throughput: one byte per cycle on the result side while a run is queued and result.ready is
//   high; an item gives n bytes, n from 0 to 5, sent by the byte-wide serialiser in the back part
// a two-entry run queue lets the front take items while bytes wait to be taken
// reset clears the oid arc position, the queue pointers and the byte index
`timescale 1ns / 1ps
`default_nettype none
`include "ber_value_encoder_macros.svh"

// ---------------------------------------------------------------------------
// ber_value_encoder
// asn.1 ber content byte encoder for integers, lengths, oid arcs and raw bytes
// ---------------------------------------------------------------------------
module ber_value_encoder
	import bve_pkg::*;
#(
	parameter int VALUE_BYTES = bve_pkg::VALUE_BYTES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bve_in_if.sink    item,
	bve_out_if.source result
);

	logic       push;
	bve_run_t   push_run;
	logic       pop;
	bve_run_t   head;
	bve_qstat_t stat;

	bve_front #(
		.VALUE_BYTES (VALUE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.q_full   (stat.full),
		.push     (push),
		.push_run (push_run)
	);

	bve_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	bve_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.result (result)
	);

	// offered bytes always belong to a non-empty run
	`BVE_ASSERT_IMPL(a_run_len, result.valid, result.run_length != 3'd0 && result.run_length <= 3'd5)
	// a run is not left half sent
	`BVE_ASSERT_NEXT(a_run_cont, result.valid && result.ready && !result.last_byte, result.valid)
	// queue occupancy stays within its depth
	`BVE_ASSERT_IMPL(a_q_bound, push && stat.full, 1'b0)

endmodule

`default_nettype wire

// ===== src/bve_front.sv =====
// ---------------------------------------------------------------------------
// bve_front
// accepts value elements, tracks oid arcs and builds each item's byte run
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bve_front
	import bve_pkg::*;
#(
	parameter int VALUE_BYTES = bve_pkg::VALUE_BYTES
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	bve_in_if.sink        item,
	input  wire logic     q_full,
	output logic          push,
	output bve_run_t      push_run
);

	bve_arc_t    arc_pos_q, arc_pos_d;
	logic [31:0] first_x40_q;
	logic        capture;
	bve_run_t    run;
	logic        xfer;

	function automatic bve_run_t enc_int(input logic [31:0] v, input logic is_signed);
		bve_run_t        r;
		logic [63:0]     ext;
		logic [7:0][7:0] ib;
		logic            neg;
		logic [7:0]      fill;
		int              top;
		int              idx;
		logic            pad;
		r    = '0;
		ext  = is_signed ? {{32{v[31]}}, v} : {32'b0, v};
		ib   = ext;
		neg  = is_signed && ib[VALUE_BYTES-1][7];
		fill = {8{neg}};
		top  = VALUE_BYTES - 1;
		for (int i = VALUE_BYTES - 1; i > 0; i--) begin
			if (top == i && ib[i] == fill) begin
				top = i - 1;
			end
		end
		pad = ib[top[2:0]][7] != neg;
		for (int k = 0; k < MAX_RUN; k++) begin
			idx = top + int'(pad) - k;
			if (k == 0 && pad) begin
				r.bytes[k] = fill;
			end else if (idx >= 0) begin
				r.bytes[k] = ib[idx[2:0]];
			end
		end
		if (top + 1 + int'(pad) > MAX_RUN) begin
			r.count = RUN_W'(MAX_RUN);
		end else begin
			r.count = RUN_W'(top + 1 + int'(pad));
		end
		return r;
	endfunction

	function automatic bve_run_t enc_len(input logic [31:0] v);
		bve_run_t r;
		int       top;
		int       idx;
		r = '0;
		if (v <= 32'd127) begin
			r.bytes[0] = v[7:0];
			r.count    = RUN_W'(1);
		end else begin
			top = 3;
			for (int i = 3; i > 0; i--) begin
				if (top == i && v[8*i +: 8] == 8'h00) begin
					top = i - 1;
				end
			end
			r.bytes[0] = 8'h80 | 8'(top + 1);
			for (int k = 1; k < MAX_RUN; k++) begin
				idx = top - (k - 1);
				if (idx >= 0) begin
					r.bytes[k] = v[8*idx[1:0] +: 8];
				end
			end
			r.count = RUN_W'(top + 2);
		end
		return r;
	endfunction

	function automatic bve_run_t enc_b128(input logic [31:0] v);
		bve_run_t        r;
		logic [4:0][6:0] g;
		int              n;
		r = '0;
		for (int j = 0; j < 4; j++) begin
			g[j] = v[7*j +: 7];
		end
		g[4] = {3'b000, v[31:28]};
		n    = 1;
		for (int j = 1; j < 5; j++) begin
			if (g[j] != 7'd0) begin
				n = j + 1;
			end
		end
		for (int m = 0; m < MAX_RUN; m++) begin
			if (m < n) begin
				r.bytes[m] = {m != n - 1, g[3'(n - 1 - m)]};
			end
		end
		r.count = RUN_W'(n);
		return r;
	endfunction

	assign item.ready = !q_full;
	assign xfer       = item.valid && item.ready;
	assign push       = xfer && (run.count != '0);
	assign push_run   = run;

	always_comb begin
		run       = '0;
		arc_pos_d = arc_pos_q;
		capture   = 1'b0;
		unique case (bve_op_t'(item.operation))
			OP_SINT: begin
				run = enc_int(item.value_word, 1'b1);
			end
			OP_UINT: begin
				run = enc_int(item.value_word, 1'b0);
			end
			OP_OID: begin
				unique case (arc_pos_q)
					ARC_FIRST: begin
						if (item.last_element) begin
							run = enc_b128(item.value_word);
						end else begin
							capture   = 1'b1;
							arc_pos_d = ARC_SECOND;
						end
					end
					ARC_SECOND: begin
						run       = enc_b128(first_x40_q + item.value_word);
						arc_pos_d = item.last_element ? ARC_FIRST : ARC_LATER;
					end
					default: begin
						run       = enc_b128(item.value_word);
						arc_pos_d = item.last_element ? ARC_FIRST : ARC_LATER;
					end
				endcase
			end
			OP_RAW: begin
				run.bytes[0] = item.value_word[7:0];
				run.count    = RUN_W'(1);
			end
			OP_LEN: begin
				run = enc_len(item.value_word);
			end
			default: begin
				run = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_pos_q <= ARC_FIRST;
		end else if (xfer && bve_op_t'(item.operation) == OP_OID) begin
			arc_pos_q <= arc_pos_d;
		end
	end

	// first arc kept pre-scaled by 40
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x40_q <= '0;
		end else if (xfer && capture) begin
			first_x40_q <= (item.value_word << 5) + (item.value_word << 3);
		end
	end

endmodule

`default_nettype wire

// ===== src/bve_queue.sv =====
// ---------------------------------------------------------------------------
// bve_queue
// short queue of byte runs between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bve_queue
	import bve_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire bve_run_t  push_run,
	input  wire logic      pop,
	output bve_run_t       head,
	output bve_qstat_t     stat
);

	bve_run_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign stat.count = count_q;
	assign stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign stat.empty = count_q == '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/bve_back.sv =====
// ---------------------------------------------------------------------------
// bve_back
// sends the head run one byte per transfer and retires it on its last byte
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bve_back
	import bve_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire bve_run_t  head,
	input  wire bve_qstat_t stat,
	output logic           pop,
	bve_out_if.source      result
);

	logic [RUN_W-1:0] idx_q;
	logic             last;
	logic             xfer;

	assign last              = idx_q == head.count - 1'b1;
	assign result.valid      = !stat.empty;
	assign result.out_byte   = head.bytes[idx_q];
	assign result.last_byte  = last;
	assign result.run_length = head.count;
	assign xfer              = result.valid && result.ready;
	assign pop               = xfer && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (xfer) begin
			idx_q <= last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

`default_nettype wire
